// ===== rtl/line_segment_quad_expander_top_assert.svh =====
// assertion macro used by the checker
`ifndef LINE_SEGMENT_QUAD_EXPANDER_TOP_ASSERT_SVH
`define LINE_SEGMENT_QUAD_EXPANDER_TOP_ASSERT_SVH

// concurrent check on the rising clock edge, off while in reset
`define LSQE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/lsqe_pkg.sv =====
// shared types, constants and helpers of the line segment quad expander
package lsqe_pkg;

  localparam int SampleW = 16;
  localparam int CoordW  = 18;
  localparam int ZW      = 18;
  localparam int HwW     = 20;
  localparam int MlW     = 16;
  localparam int QuotW   = 21;
  localparam int DirW    = 22;
  localparam int NumW    = 38;
  localparam int SqW     = 36;
  localparam int OutW    = 24;
  localparam int SumW    = 26;

  localparam logic [2:0] ADDR_HALF_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_MIN_LENGTH = 3'd4;

  localparam logic [2:0] VTX_FIRST = 3'd0;
  localparam logic [2:0] VTX_2     = 3'd2;
  localparam logic [2:0] VTX_4     = 3'd4;
  localparam logic [2:0] VTX_LAST  = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
    logic                     fs;
    logic                     fe;
  } side_t;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic signed [DirW-1:0]   ux;
    logic signed [DirW-1:0]   uy;
    logic [ZW-1:0]            z;
    logic                     fs;
    logic                     fe;
  } seg_t;

  function automatic logic signed [OutW-1:0] sat24(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(signed'(25'sd8388607));
    lo = -SumW'(signed'(25'sd8388608));
    if (v > hi) begin
      sat24 = {1'b0, {(OutW-1){1'b1}}};
    end else if (v < lo) begin
      sat24 = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      sat24 = v[OutW-1:0];
    end
  endfunction

endpackage

// ===== rtl/line_segment_quad_expander_top.sv =====
// line segment quad expander: top level with register port and input stages
//
// Input channel (in_valid_i / in_stall_o) takes one segment: start and end
// stereo samples in Q0.16 plus the frame marks. Output channel
// (out_valid_o / out_stall_i) gives six vertex transfers per segment, vertex
// 0..5 in order, last_vertex_o high on the sixth.
// The path from the input transfer to the first vertex is 46 register stages:
// two prep stages, a 19-stage square root, a 24-stage divider and the vertex
// register. Throughput is set by the vertex sequencer, which emits one vertex
// per cycle while out_stall_i is low and takes the next segment as the sixth
// vertex leaves. Segments still enter back to back while the pipe has room.
// A stall at the output holds the current vertex stable; while a finished
// segment waits at the divider output, every stage freezes and in_stall_o
// is high; nothing is dropped or repeated. Registers: half_width at byte 0,
// min_length at byte 4. The user must write them over the APB-style port
// only while the block is idle; the block does not enforce this. Reset
// empties the pipe and loads half_width = 655, min_length = 0.
module line_segment_quad_expander_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        start_left_i,
  input  logic [15:0]        start_right_i,
  input  logic [15:0]        end_left_i,
  input  logic [15:0]        end_right_i,
  input  logic               frame_start_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         vertex_number_o,
  output logic signed [23:0] pos_x_o,
  output logic signed [23:0] pos_y_o,
  output logic signed [23:0] attr_a_o,
  output logic signed [23:0] attr_b_o,
  output logic [17:0]        seg_length_o,
  output logic               tex_u_o,
  output logic               tex_v_o,
  output logic               last_vertex_o,
  output logic               first_of_frame_o,
  output logic               end_of_frame_o
);
  import lsqe_pkg::*;

  logic [HwW-1:0] hw_q;
  logic [MlW-1:0] ml_q;
  logic           wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HwW'(655);
      ml_q <= '0;
    end else if (wr) begin
      unique case (paddr)
        ADDR_HALF_WIDTH: hw_q <= pwdata[HwW-1:0];
        ADDR_MIN_LENGTH: ml_q <= pwdata[MlW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_HALF_WIDTH: prdata = {{(32-HwW){1'b0}}, hw_q};
      ADDR_MIN_LENGTH: prdata = {{(32-MlW){1'b0}}, ml_q};
      default:         prdata = '0;
    endcase
  end

  // whole pipe moves together unless its head is blocked
  logic  adv;
  logic  take;
  logic  div_vld;
  seg_t  div_seg;

  assign adv        = !div_vld || take;
  assign in_stall_o = !adv;

  side_t side_d;
  side_t s1_q;
  side_t s2_q;
  logic  s1_vld_q;
  logic  s2_vld_q;
  logic [34:0] dxx_q;
  logic [34:0] dyy_q;
  logic signed [2*CoordW-1:0] dxx;
  logic signed [2*CoordW-1:0] dyy;

  always_comb begin
    side_d.px = signed'({1'b0, start_left_i, 1'b0}) - signed'(CoordW'(65536));
    side_d.py = signed'({1'b0, start_right_i, 1'b0}) - signed'(CoordW'(65536));
    side_d.qx = signed'({1'b0, end_left_i, 1'b0}) - signed'(CoordW'(65536));
    side_d.qy = signed'({1'b0, end_right_i, 1'b0}) - signed'(CoordW'(65536));
    side_d.dx = side_d.qx - side_d.px;
    side_d.dy = side_d.qy - side_d.py;
    side_d.fs = frame_start_i;
    side_d.fe = frame_end_i;
  end

  assign dxx = s1_q.dx * s1_q.dx;
  assign dyy = s1_q.dy * s1_q.dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= side_d;
      s2_q  <= s1_q;
      dxx_q <= dxx[34:0];
      dyy_q <= dyy[34:0];
    end
  end

  logic            sq_vld;
  logic [ZW-1:0]   sq_z;
  side_t           sq_side;

  lsqe_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s2_vld_q),
    .dxx_i   (dxx_q),
    .dyy_i   (dyy_q),
    .side_i  (s2_q),
    .valid_o (sq_vld),
    .z_o     (sq_z),
    .side_o  (sq_side)
  );

  lsqe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sq_vld),
    .z_i     (sq_z),
    .side_i  (sq_side),
    .hw_i    (hw_q),
    .ml_i    (ml_q),
    .valid_o (div_vld),
    .seg_o   (div_seg)
  );

  lsqe_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (div_vld),
    .seg_i            (div_seg),
    .hw_i             (hw_q),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .vertex_number_o  (vertex_number_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .attr_a_o         (attr_a_o),
    .attr_b_o         (attr_b_o),
    .seg_length_o     (seg_length_o),
    .tex_u_o          (tex_u_o),
    .tex_v_o          (tex_v_o),
    .last_vertex_o    (last_vertex_o),
    .first_of_frame_o (first_of_frame_o),
    .end_of_frame_o   (end_of_frame_o)
  );

endmodule

// ===== rtl/lsqe_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module lsqe_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [34:0]          dxx_i,
  input  logic [34:0]          dyy_i,
  input  lsqe_pkg::side_t      side_i,
  output logic                 valid_o,
  output logic [lsqe_pkg::ZW-1:0] z_o,
  output lsqe_pkg::side_t      side_o
);
  import lsqe_pkg::*;

  logic [SqW-1:0] rem_q  [0:ZW];
  logic [ZW-1:0]  root_q [0:ZW];
  logic           vld_q  [0:ZW];
  side_t          side_q [0:ZW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0]  <= {1'b0, dxx_i} + {1'b0, dyy_i};
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < ZW; k++) begin : g_stage
    localparam int B = ZW - 1 - k;
    logic [SqW-1:0] trial;
    assign trial = ({{(SqW-ZW){1'b0}}, root_q[k]} << (B + 1)) + (SqW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[k+1] <= side_q[k];
        if (rem_q[k] >= trial) begin
          rem_q[k+1]  <= rem_q[k] - trial;
          root_q[k+1] <= root_q[k] | (ZW'(1) << B);
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k];
        end
      end
    end
  end

  assign valid_o = vld_q[ZW];
  assign z_o     = root_q[ZW];
  assign side_o  = side_q[ZW];

endmodule

// ===== rtl/lsqe_div.sv =====
// direction scaling: rounded |d|*hw/z by a pipelined restoring divider
module lsqe_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  logic [lsqe_pkg::ZW-1:0]  z_i,
  input  lsqe_pkg::side_t          side_i,
  input  logic [lsqe_pkg::HwW-1:0] hw_i,
  input  logic [lsqe_pkg::MlW-1:0] ml_i,
  output logic                     valid_o,
  output lsqe_pkg::seg_t           seg_o
);
  import lsqe_pkg::*;

  localparam int NSt = QuotW + 2;

  logic             vld_q   [0:NSt-1];
  side_t            side_q  [0:NSt-1];
  logic [ZW-1:0]    z_q     [0:NSt-1];
  logic             degen_q [0:NSt-1];
  logic [NumW-1:0]  remx_q  [1:NSt-1];
  logic [NumW-1:0]  remy_q  [1:NSt-1];
  logic [QuotW-1:0] qtx_q   [1:NSt-1];
  logic [QuotW-1:0] qty_q   [1:NSt-1];
  logic [36:0]      prodx_q;
  logic [36:0]      prody_q;

  logic [16:0] magx;
  logic [16:0] magy;
  logic [CoordW-1:0] negx;
  logic [CoordW-1:0] negy;

  assign negx = -side_i.dx;
  assign negy = -side_i.dy;
  assign magx = side_i.dx[CoordW-1] ? negx[16:0] : side_i.dx[16:0];
  assign magy = side_i.dy[CoordW-1] ? negy[16:0] : side_i.dy[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
      vld_q[1] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
      vld_q[1] <= vld_q[0];
    end
  end

  // products first, rounding offset added one stage later
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0]  <= side_i;
      z_q[0]     <= z_i;
      degen_q[0] <= (z_i <= {{(ZW-MlW){1'b0}}, ml_i});
      prodx_q    <= {20'd0, magx} * {17'd0, hw_i};
      prody_q    <= {20'd0, magy} * {17'd0, hw_i};
      side_q[1]  <= side_q[0];
      z_q[1]     <= z_q[0];
      degen_q[1] <= degen_q[0];
      remx_q[1]  <= {1'b0, prodx_q} + {{(NumW-ZW+1){1'b0}}, z_q[0][ZW-1:1]};
      remy_q[1]  <= {1'b0, prody_q} + {{(NumW-ZW+1){1'b0}}, z_q[0][ZW-1:1]};
      qtx_q[1]   <= '0;
      qty_q[1]   <= '0;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    localparam int B = QuotW - 1 - k;
    logic [NumW-1:0] dsh;
    assign dsh = {{(NumW-ZW){1'b0}}, z_q[k+1]} << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+2] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+2] <= vld_q[k+1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[k+2]  <= side_q[k+1];
        z_q[k+2]     <= z_q[k+1];
        degen_q[k+2] <= degen_q[k+1];
        if (remx_q[k+1] >= dsh) begin
          remx_q[k+2] <= remx_q[k+1] - dsh;
          qtx_q[k+2]  <= qtx_q[k+1] | (QuotW'(1) << B);
        end else begin
          remx_q[k+2] <= remx_q[k+1];
          qtx_q[k+2]  <= qtx_q[k+1];
        end
        if (remy_q[k+1] >= dsh) begin
          remy_q[k+2] <= remy_q[k+1] - dsh;
          qty_q[k+2]  <= qty_q[k+1] | (QuotW'(1) << B);
        end else begin
          remy_q[k+2] <= remy_q[k+1];
          qty_q[k+2]  <= qty_q[k+1];
        end
      end
    end
  end

  // last stage: sign back on, short segment falls back to (hw, 0)
  logic signed [DirW-1:0] sqx;
  logic signed [DirW-1:0] sqy;
  logic                   vld_out_q;
  seg_t                   seg_q;

  assign sqx = signed'({1'b0, qtx_q[NSt-1]});
  assign sqy = signed'({1'b0, qty_q[NSt-1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (adv_i) begin
      vld_out_q <= vld_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      seg_q.px <= side_q[NSt-1].px;
      seg_q.py <= side_q[NSt-1].py;
      seg_q.qx <= side_q[NSt-1].qx;
      seg_q.qy <= side_q[NSt-1].qy;
      seg_q.z  <= z_q[NSt-1];
      seg_q.fs <= side_q[NSt-1].fs;
      seg_q.fe <= side_q[NSt-1].fe;
      if (degen_q[NSt-1]) begin
        seg_q.ux <= signed'({2'b00, hw_i});
        seg_q.uy <= '0;
      end else begin
        seg_q.ux <= side_q[NSt-1].dx[CoordW-1] ? -sqx : sqx;
        seg_q.uy <= side_q[NSt-1].dy[CoordW-1] ? -sqy : sqy;
      end
    end
  end

  assign valid_o = vld_out_q;
  assign seg_o   = seg_q;

endmodule

// ===== rtl/lsqe_emit.sv =====
// vertex sequencer: holds one segment and hands out its six vertices
module lsqe_emit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  lsqe_pkg::seg_t           seg_i,
  input  logic [lsqe_pkg::HwW-1:0] hw_i,
  output logic                     take_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               vertex_number_o,
  output logic signed [23:0]       pos_x_o,
  output logic signed [23:0]       pos_y_o,
  output logic signed [23:0]       attr_a_o,
  output logic signed [23:0]       attr_b_o,
  output logic [17:0]              seg_length_o,
  output logic                     tex_u_o,
  output logic                     tex_v_o,
  output logic                     last_vertex_o,
  output logic                     first_of_frame_o,
  output logic                     end_of_frame_o
);
  import lsqe_pkg::*;

  logic       vld_q;
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;
  seg_t       seg_q;
  logic       xfer;

  assign xfer   = vld_q && !out_stall_i;
  assign take_o = !vld_q || (xfer && cnt_q == VTX_LAST);

  always_comb begin
    cnt_d = cnt_q;
    if (take_o) begin
      cnt_d = VTX_FIRST;
    end else if (xfer) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= VTX_FIRST;
    end else begin
      cnt_q <= cnt_d;
      if (take_o) begin
        vld_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      seg_q <= seg_i;
    end
  end

  logic at_end;
  logic plus;
  logic signed [SumW-1:0] bx, by, vx, vy, hw_s, za;

  always_comb begin
    at_end = 1'b0;
    plus   = 1'b0;
    case (cnt_q)
      VTX_2:    at_end = 1'b1;
      VTX_4:    at_end = 1'b1;
      VTX_LAST: begin
        at_end = 1'b1;
        plus   = 1'b1;
      end
      default:  plus = cnt_q[0];
    endcase
  end

  assign hw_s = signed'({{(SumW-HwW){1'b0}}, hw_i});
  assign za   = signed'({{(SumW-ZW){1'b0}}, seg_q.z}) + hw_s;
  assign bx = at_end ? SumW'(seg_q.qx) + SumW'(seg_q.ux) : SumW'(seg_q.px) - SumW'(seg_q.ux);
  assign by = at_end ? SumW'(seg_q.qy) + SumW'(seg_q.uy) : SumW'(seg_q.py) - SumW'(seg_q.uy);
  // normal is (-uy, ux)
  assign vx = plus ? bx - SumW'(seg_q.uy) : bx + SumW'(seg_q.uy);
  assign vy = plus ? by + SumW'(seg_q.ux) : by - SumW'(seg_q.ux);

  assign out_valid_o      = vld_q;
  assign vertex_number_o  = cnt_q;
  assign pos_x_o          = sat24(vx);
  assign pos_y_o          = sat24(vy);
  assign attr_a_o         = at_end ? sat24(za) : sat24(-hw_s);
  assign attr_b_o         = plus ? sat24(hw_s) : sat24(-hw_s);
  assign seg_length_o     = seg_q.z;
  assign tex_u_o          = plus;
  assign tex_v_o          = at_end;
  assign last_vertex_o    = (cnt_q == VTX_LAST);
  assign first_of_frame_o = seg_q.fs;
  assign end_of_frame_o   = seg_q.fe;

endmodule

// ===== rtl/lsqe_checker.sv =====
// port-level checks of the quad expander, bound to the top level
`include "line_segment_quad_expander_top_assert.svh"

module lsqe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         vertex_number_o,
  input logic signed [23:0] pos_x_o,
  input logic signed [23:0] pos_y_o,
  input logic               last_vertex_o
);
  import lsqe_pkg::*;

  // a stalled vertex holds
  `LSQE_ASSERT(a_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(vertex_number_o) && $stable(pos_x_o) && $stable(pos_y_o))
  // the rest of a segment follows without gaps
  `LSQE_ASSERT(a_no_gap, out_valid_o && !out_stall_i && !last_vertex_o |=> out_valid_o)
  // vertices of a segment count up by one per transfer
  `LSQE_ASSERT(a_count, out_valid_o && !out_stall_i && !last_vertex_o |=> vertex_number_o == $past(vertex_number_o) + 3'd1)
  // last mark only on the sixth vertex
  `LSQE_ASSERT(a_last, out_valid_o |-> last_vertex_o == (vertex_number_o == VTX_LAST))

endmodule

bind line_segment_quad_expander_top lsqe_checker u_lsqe_checker (.*);
